>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the Steim frame word decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/sfwd_pkg.sv
// ----------------------------------------------------------------------------
// Steim frame word decoder package
// Control codes, subcodes, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfwd_pkg;

   // Number of sample slots carried by one result.
   localparam int SLOT_COUNT = 7;
   localparam int SAMPLE_WIDTH = 32;

   // Data words in one frame; positions at or above this decode as ordinary words.
   localparam int WORDS_PER_FRAME = 15;

   // Control codes from the frame header.
   localparam logic [1:0] CODE_NONE = 2'd0;
   localparam logic [1:0] CODE_BYTE = 2'd1;
   localparam logic [1:0] CODE_HALF = 2'd2;
   localparam logic [1:0] CODE_WORD = 2'd3;

   // Steim 2 subcodes for control code 2.
   localparam logic [1:0] SUB2_UNDEFINED = 2'd0;
   localparam logic [1:0] SUB2_ONE_30    = 2'd1;
   localparam logic [1:0] SUB2_TWO_15    = 2'd2;
   localparam logic [1:0] SUB2_THREE_10  = 2'd3;

   // Steim 2 subcodes for control code 3.
   localparam logic [1:0] SUB3_FIVE_6    = 2'd0;
   localparam logic [1:0] SUB3_SIX_5     = 2'd1;
   localparam logic [1:0] SUB3_SEVEN_4   = 2'd2;
   localparam logic [1:0] SUB3_UNDEFINED = 2'd3;

   // Compression level that selects Steim 2 decoding.
   localparam logic [1:0] LEVEL_STEIM2 = 2'd2;
   localparam logic [1:0] LEVEL_RESET  = 2'd1;

   // Frame positions of the integration constants.
   localparam logic [3:0] FRAME_WORD_FORWARD = 4'd0;
   localparam logic [3:0] FRAME_WORD_REVERSE = 4'd1;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEIM_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTEXT_CHECK = 2'd1;
   localparam int CSR_DATA_WIDTH = 32;

   // Differences unpacked from one data word.
   typedef struct packed {
      logic [SLOT_COUNT-1:0][SAMPLE_WIDTH-1:0] delta;
      logic [2:0]                              count;
      logic                                    bad;
   } sfwd_unpack_type;

endpackage

>>> hdl/sfwd_unpack.sv
// ----------------------------------------------------------------------------
// Steim word unpacker
// Splits one data word into sign-extended differences by code and subcode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfwd_unpack
   import sfwd_pkg::*;
(
   input  logic [31:0]     word,
   input  logic [1:0]      code,
   input  logic            level_steim2,
   output sfwd_unpack_type result
);

   logic [1:0] subcode;

   assign subcode = word[31:30];

   // Slots are taken from the most significant end of the word.
   always_comb begin
      result = '0;
      case (code)
         CODE_NONE: begin
            result.count = 3'd0;
         end
         CODE_BYTE: begin
            for (int s = 0; s < 4; s++) begin
               result.delta[s] = 32'($signed(word[8*(3-s) +: 8]));
            end
            result.count = 3'd4;
         end
         CODE_HALF: begin
            if (!level_steim2) begin
               for (int s = 0; s < 2; s++) begin
                  result.delta[s] = 32'($signed(word[16*(1-s) +: 16]));
               end
               result.count = 3'd2;
            end else begin
               case (subcode)
                  SUB2_ONE_30: begin
                     result.delta[0] = 32'($signed(word[29:0]));
                     result.count = 3'd1;
                  end
                  SUB2_TWO_15: begin
                     for (int s = 0; s < 2; s++) begin
                        result.delta[s] = 32'($signed(word[15*(1-s) +: 15]));
                     end
                     result.count = 3'd2;
                  end
                  SUB2_THREE_10: begin
                     for (int s = 0; s < 3; s++) begin
                        result.delta[s] = 32'($signed(word[10*(2-s) +: 10]));
                     end
                     result.count = 3'd3;
                  end
                  default: begin
                     // Subcode 0 under code 2 is not defined.
                     result.bad = 1'b1;
                  end
               endcase
            end
         end
         CODE_WORD: begin
            if (!level_steim2) begin
               result.delta[0] = word;
               result.count = 3'd1;
            end else begin
               case (subcode)
                  SUB3_FIVE_6: begin
                     for (int s = 0; s < 5; s++) begin
                        result.delta[s] = 32'($signed(word[6*(4-s) +: 6]));
                     end
                     result.count = 3'd5;
                  end
                  SUB3_SIX_5: begin
                     for (int s = 0; s < 6; s++) begin
                        result.delta[s] = 32'($signed(word[5*(5-s) +: 5]));
                     end
                     result.count = 3'd6;
                  end
                  SUB3_SEVEN_4: begin
                     for (int s = 0; s < 7; s++) begin
                        result.delta[s] = 32'($signed(word[4*(6-s) +: 4]));
                     end
                     result.count = 3'd7;
                  end
                  default: begin
                     // Subcode 3 under code 3 is not defined.
                     result.bad = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

>>> hdl/steim_frame_word_decoder_top.sv
// ----------------------------------------------------------------------------
// Steim frame word decoder
// Decodes Steim 1 / Steim 2 frame words and integrates them into samples.
// ----------------------------------------------------------------------------
// The decoder accepts one frame data word per clock while req_stall is low
// and returns one result transaction per word: the word is captured in an
// input register, then unpacking and the seven-slot running sum are done
// combinationally into the result register, which also updates the record
// state (accumulator, integration constants, first difference, sticky
// flags). The result is valid once the word has moved from the input
// register into the result register. Sustained throughput is one word per
// cycle while the output is not stalled; the critical path is the chain of
// up to seven 32-bit adds of the running sum. A result waiting on a stalled
// output does not keep a new word out of an empty input register; once both
// registers are full, req_stall follows rsp_stall in the same cycle.
// The csr port is always ready and is to be written only while the decoder
// holds no word.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module steim_frame_word_decoder_top
   import sfwd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_data_word,
   input  logic [1:0]                 req_code,
   input  logic [3:0]                 req_word_index,
   input  logic                       req_first_of_record,
   input  logic                       req_last_of_record,
   input  logic                       req_begin_event,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [31:0]         rsp_sample_a,
   output logic signed [31:0]         rsp_sample_b,
   output logic signed [31:0]         rsp_sample_c,
   output logic signed [31:0]         rsp_sample_d,
   output logic signed [31:0]         rsp_sample_e,
   output logic signed [31:0]         rsp_sample_f,
   output logic signed [31:0]         rsp_sample_g,
   output logic [2:0]                 rsp_sample_count,
   output logic                       rsp_bad_type,
   output logic                       rsp_reverse_mismatch,
   output logic                       rsp_context_mismatch,
   output logic                       rsp_record_done,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Configuration registers.
   logic [1:0]  level_ff;
   logic        ctx_enable_ff;

   // Input stage.
   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_word_ff;
   logic [1:0]  in_code_ff;
   logic [3:0]  in_index_ff;
   logic        in_first_ff;
   logic        in_last_ff;
   logic        in_begev_ff;

   // Record state.
   logic [31:0] acc_ff, acc_in;
   logic [31:0] fwd_ff, fwd_in;
   logic [31:0] rev_ff, rev_in;
   logic        found_ff, found_in;
   logic [31:0] hold_word_ff, hold_word_in;
   logic        hold_valid_ff, hold_valid_in;
   logic        delta_pending_ff, delta_pending_in;
   logic [31:0] first_delta_ff, first_delta_in;
   logic        bad_ff, bad_in;
   logic [31:0] prev_rev_ff, prev_rev_in;
   logic        ctx_valid_ff, ctx_valid_in;

   // Result stage.
   logic                                    out_valid_ff, out_valid_in;
   logic [SLOT_COUNT-1:0][SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic [2:0]                              count_ff;
   logic                                    bad_out_ff;
   logic                                    rev_bad_ff, rev_bad_in;
   logic                                    ctx_bad_ff, ctx_bad_in;
   logic                                    done_ff;

   // Handshake and working signals.
   logic            accept;
   logic            out_free;
   logic            fire;
   sfwd_unpack_type unpacked;
   logic [SLOT_COUNT-1:0][SAMPLE_WIDTH-1:0] delta_eff;
   logic [31:0]     acc_eff;
   logic [31:0]     fwd_eff;
   logic [31:0]     rev_eff;
   logic            found_eff;
   logic [31:0]     hold_word_eff;
   logic            hold_valid_eff;
   logic            delta_pending_eff;
   logic [31:0]     first_delta_eff;
   logic            bad_eff;
   logic            load_const;
   logic            has_samples;
   logic [31:0]     running;

   // Handshake: the result register frees when empty or being taken.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= LEVEL_RESET;
         ctx_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_STEIM_LEVEL) begin
            level_ff <= csr_wdata[1:0];
         end
         if (csr_index == CSR_CONTEXT_CHECK) begin
            ctx_enable_ff <= csr_wdata[0];
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_word_ff  <= req_data_word;
         in_code_ff  <= req_code;
         in_index_ff <= req_word_index;
         in_first_ff <= req_first_of_record;
         in_last_ff  <= req_last_of_record;
         in_begev_ff <= req_begin_event;
      end
   end

   // Word unpacking.
   sfwd_unpack u_unpack (
      .word         (in_word_ff),
      .code         (in_code_ff),
      .level_steim2 (level_ff == LEVEL_STEIM2),
      .result       (unpacked)
   );

   // Record state as seen by this word, after the record-start clear.
   always_comb begin
      acc_eff           = in_first_ff ? '0 : acc_ff;
      fwd_eff           = in_first_ff ? '0 : fwd_ff;
      rev_eff           = in_first_ff ? '0 : rev_ff;
      found_eff         = in_first_ff ? 1'b0 : found_ff;
      hold_word_eff     = in_first_ff ? '0 : hold_word_ff;
      hold_valid_eff    = in_first_ff ? 1'b0 : hold_valid_ff;
      delta_pending_eff = in_first_ff ? 1'b1 : delta_pending_ff;
      first_delta_eff   = in_first_ff ? '0 : first_delta_ff;
      bad_eff           = in_first_ff ? 1'b0 : bad_ff;
   end

   // Integration constants and the held frame word 0.
   always_comb begin
      load_const = (in_code_ff == CODE_NONE) && (in_index_ff == FRAME_WORD_REVERSE) &&
                   hold_valid_eff && !found_eff;
      fwd_in        = load_const ? hold_word_eff : fwd_eff;
      rev_in        = load_const ? in_word_ff : rev_eff;
      found_in      = found_eff || load_const;
      hold_valid_in = (in_code_ff == CODE_NONE) && (in_index_ff == FRAME_WORD_FORWARD);
      hold_word_in  = hold_valid_in ? in_word_ff : hold_word_eff;
      bad_in        = bad_eff || unpacked.bad;
   end

   // Running sum over the slots; the first difference of a record is
   // dropped when the forward constant already seeded the accumulator.
   always_comb begin
      has_samples      = unpacked.count != 3'd0;
      delta_pending_in = delta_pending_eff && !has_samples;
      first_delta_in   = (delta_pending_eff && has_samples) ? unpacked.delta[0]
                                                            : first_delta_eff;
      delta_eff = unpacked.delta;
      if (delta_pending_eff && found_in) begin
         delta_eff[0] = '0;
      end
      running = (load_const && delta_pending_eff) ? hold_word_eff : acc_eff;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         sample_in[k] = '0;
         if (k < int'(unpacked.count)) begin
            running      = running + delta_eff[k];
            sample_in[k] = running;
         end
      end
      acc_in = running;
   end

   // End-of-record checks and the continuity context.
   always_comb begin
      rev_bad_in   = 1'b0;
      ctx_bad_in   = 1'b0;
      prev_rev_in  = prev_rev_ff;
      ctx_valid_in = ctx_valid_ff;
      if (in_last_ff) begin
         rev_bad_in = acc_in != rev_in;
         if (ctx_enable_ff) begin
            ctx_bad_in = ctx_valid_ff && !in_begev_ff &&
                         (fwd_in != (prev_rev_ff + first_delta_in));
            ctx_valid_in = 1'b1;
            prev_rev_in  = rev_in;
         end
      end
   end

   // Record state registers advance with each decoded word.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff           <= '0;
         fwd_ff           <= '0;
         rev_ff           <= '0;
         found_ff         <= 1'b0;
         hold_word_ff     <= '0;
         hold_valid_ff    <= 1'b0;
         delta_pending_ff <= 1'b1;
         first_delta_ff   <= '0;
         bad_ff           <= 1'b0;
         prev_rev_ff      <= '0;
         ctx_valid_ff     <= 1'b0;
      end else if (fire) begin
         acc_ff           <= acc_in;
         fwd_ff           <= fwd_in;
         rev_ff           <= rev_in;
         found_ff         <= found_in;
         hold_word_ff     <= hold_word_in;
         hold_valid_ff    <= hold_valid_in;
         delta_pending_ff <= delta_pending_in;
         first_delta_ff   <= first_delta_in;
         bad_ff           <= bad_in;
         prev_rev_ff      <= prev_rev_in;
         ctx_valid_ff     <= ctx_valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (fire) begin
         sample_ff  <= sample_in;
         count_ff   <= unpacked.count;
         bad_out_ff <= bad_in;
         rev_bad_ff <= rev_bad_in;
         ctx_bad_ff <= ctx_bad_in;
         done_ff    <= in_last_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_sample_a         = $signed(sample_ff[0]);
   assign rsp_sample_b         = $signed(sample_ff[1]);
   assign rsp_sample_c         = $signed(sample_ff[2]);
   assign rsp_sample_d         = $signed(sample_ff[3]);
   assign rsp_sample_e         = $signed(sample_ff[4]);
   assign rsp_sample_f         = $signed(sample_ff[5]);
   assign rsp_sample_g         = $signed(sample_ff[6]);
   assign rsp_sample_count     = count_ff;
   assign rsp_bad_type         = bad_out_ff;
   assign rsp_reverse_mismatch = rev_bad_ff;
   assign rsp_context_mismatch = ctx_bad_ff;
   assign rsp_record_done      = done_ff;

   // Checks are only raised on a transaction that closes a record.
   `ASSERT_SAME_CYCLE(a_flags_only_at_end, clock, reset, rsp_valid && !rsp_record_done, !rsp_reverse_mismatch && !rsp_context_mismatch)

   // An empty result carries no samples.
   `ASSERT_SAME_CYCLE(a_empty_result_zero, clock, reset, rsp_valid && (rsp_sample_count == 3'd0), rsp_sample_a == 32'sd0)

   // A word that finds the result register free shows up at the output.
   `ASSERT_NEXT_CYCLE(a_word_reaches_output, clock, reset, fire, rsp_valid)

   // An undefined type yields no samples.
   `ASSERT_SAME_CYCLE(a_bad_has_no_samples, clock, reset, unpacked.bad, unpacked.count == 3'd0)

   // A word with samples always clears the pending first difference.
   `ASSERT_NEXT_CYCLE(a_first_delta_taken, clock, reset, fire && (unpacked.count != 3'd0), !delta_pending_ff)

endmodule

>>> bench/tb_steim_frame_word_decoder_top.sv
// ----------------------------------------------------------------------------
// Steim frame word decoder testbench
// Drives frame words into the decoder with random idle and stall patterns,
// predicts every result transaction from a behavioral copy of the record
// state, and compares each sample and flag with what the decoder returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_steim_frame_word_decoder_top;
   import sfwd_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 9;
   localparam int QUIET_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_OFF_CYCLES = 150;

   // Level values beyond the two defined ones decode as Steim 1.
   localparam logic [1:0] LEVEL_STEIM1      = LEVEL_RESET;
   localparam logic [1:0] LEVEL_UNUSED_LOW  = 2'd0;
   localparam logic [1:0] LEVEL_UNUSED_HIGH = 2'd3;

   // Register indexes with no register behind them.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  code;
      logic [3:0]  position;
      logic        opens;
      logic        closes;
      logic        begin_event;
   } frame_word_type;

   typedef struct packed {
      logic [6:0][31:0] sample;
      logic [2:0]       count;
      logic             bad_type;
      logic             reverse_bad;
      logic             context_bad;
      logic             done;
   } decoded_result_type;

   typedef enum {
      RECORD_CLEAN,
      RECORD_NO_CONSTANTS,
      RECORD_NO_START,
      RECORD_BAD_CONSTANTS
   } record_shape_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [31:0]                req_data_word;
   logic [1:0]                 req_code;
   logic [3:0]                 req_word_index;
   logic                       req_first_of_record;
   logic                       req_last_of_record;
   logic                       req_begin_event;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [31:0]         rsp_sample_a;
   logic signed [31:0]         rsp_sample_b;
   logic signed [31:0]         rsp_sample_c;
   logic signed [31:0]         rsp_sample_d;
   logic signed [31:0]         rsp_sample_e;
   logic signed [31:0]         rsp_sample_f;
   logic signed [31:0]         rsp_sample_g;
   logic [2:0]                 rsp_sample_count;
   logic                       rsp_bad_type;
   logic                       rsp_reverse_mismatch;
   logic                       rsp_context_mismatch;
   logic                       rsp_record_done;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   // Behavioral copy of the decoder configuration and record state.
   logic [1:0]  level_reg;
   logic        ctx_enable;
   logic [31:0] acc;
   logic [31:0] fwd_const;
   logic [31:0] rev_const;
   logic        have_constants;
   logic [31:0] held_word;
   logic        held_valid;
   logic        delta_pending;
   logic [31:0] first_diff;
   logic        bad_seen;
   logic [31:0] prev_rev;
   logic        ctx_valid;

   decoded_result_type expected_decodes[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off_left = 0;
   int words_accepted = 0;
   int results_checked = 0;
   int records_closed = 0;
   int mismatches = 0;

   steim_frame_word_decoder_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_word        (req_data_word),
      .req_code             (req_code),
      .req_word_index       (req_word_index),
      .req_first_of_record  (req_first_of_record),
      .req_last_of_record   (req_last_of_record),
      .req_begin_event      (req_begin_event),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sample_a         (rsp_sample_a),
      .rsp_sample_b         (rsp_sample_b),
      .rsp_sample_c         (rsp_sample_c),
      .rsp_sample_d         (rsp_sample_d),
      .rsp_sample_e         (rsp_sample_e),
      .rsp_sample_f         (rsp_sample_f),
      .rsp_sample_g         (rsp_sample_g),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_bad_type         (rsp_bad_type),
      .rsp_reverse_mismatch (rsp_reverse_mismatch),
      .rsp_context_mismatch (rsp_context_mismatch),
      .rsp_record_done      (rsp_record_done),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Splits a word into sign-extended differences; returns -1 for an undefined type.
   function automatic int unpack_differences(input logic [31:0] word, input logic [1:0] code,
         input logic [1:0] level, output logic [6:0][31:0] diffs);
      int width;
      int slots;
      logic [31:0] mask;
      logic [31:0] d;
      diffs = '0;
      width = 0;
      slots = 0;
      if (code == CODE_BYTE) begin
         width = 8;
         slots = 4;
      end else if (code != CODE_NONE) begin
         if (level != LEVEL_STEIM2) begin
            width = (code == CODE_HALF) ? 16 : 32;
            slots = (code == CODE_HALF) ? 2 : 1;
         end else if (code == CODE_HALF) begin
            case (word[31:30])
               SUB2_ONE_30: begin
                  width = 30;
                  slots = 1;
               end
               SUB2_TWO_15: begin
                  width = 15;
                  slots = 2;
               end
               SUB2_THREE_10: begin
                  width = 10;
                  slots = 3;
               end
               default: return -1;
            endcase
         end else begin
            case (word[31:30])
               SUB3_FIVE_6: begin
                  width = 6;
                  slots = 5;
               end
               SUB3_SIX_5: begin
                  width = 5;
                  slots = 6;
               end
               SUB3_SEVEN_4: begin
                  width = 4;
                  slots = 7;
               end
               default: return -1;
            endcase
         end
      end
      mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
      for (int s = 0; s < slots; s++) begin
         d = (word >> (width * (slots - 1 - s))) & mask;
         if (width < 32 && d[width-1]) d = d | ~mask;
         diffs[s] = d;
      end
      return slots;
   endfunction

   task automatic clear_record_state();
      acc = '0;
      fwd_const = '0;
      rev_const = '0;
      have_constants = 1'b0;
      held_word = '0;
      held_valid = 1'b0;
      delta_pending = 1'b1;
      first_diff = '0;
      bad_seen = 1'b0;
   endtask

   // Advances the record state by one accepted word and queues its result.
   task automatic integrate_word(input frame_word_type w);
      decoded_result_type r;
      logic [6:0][31:0] diffs;
      int n;
      r = '0;
      if (w.opens) clear_record_state();

      // A code-0 word 1 right after a held code-0 word 0 supplies the constants.
      if (w.code == CODE_NONE && w.position == FRAME_WORD_REVERSE && held_valid &&
          !have_constants) begin
         fwd_const = held_word;
         rev_const = w.word;
         have_constants = 1'b1;
         if (delta_pending) acc = fwd_const;
      end
      held_valid = (w.code == CODE_NONE && w.position == FRAME_WORD_FORWARD);
      if (held_valid) held_word = w.word;

      // The first difference of a record is dropped once constants are known.
      n = unpack_differences(w.word, w.code, level_reg, diffs);
      if (n < 0) begin
         bad_seen = 1'b1;
      end else begin
         for (int s = 0; s < n; s++) begin
            if (delta_pending) begin
               delta_pending = 1'b0;
               first_diff = diffs[s];
               if (!have_constants) acc = acc + diffs[s];
            end else begin
               acc = acc + diffs[s];
            end
            r.sample[s] = acc;
         end
         r.count = 3'(n);
      end
      r.bad_type = bad_seen;

      // End-of-record checks.
      if (w.closes) begin
         r.reverse_bad = (acc != rev_const);
         if (ctx_enable) begin
            r.context_bad = ctx_valid && !w.begin_event &&
                            (fwd_const != prev_rev + first_diff);
            ctx_valid = 1'b1;
            prev_rev = rev_const;
         end
      end
      r.done = w.closes;
      expected_decodes.push_back(r);
   endtask

   function automatic frame_word_type make_word(input logic [31:0] word,
         input logic [1:0] code, input logic [3:0] position, input logic opens,
         input logic closes, input logic begin_event);
      frame_word_type w;
      w.word = word;
      w.code = code;
      w.position = position;
      w.opens = opens;
      w.closes = closes;
      w.begin_event = begin_event;
      return w;
   endfunction

   // Random data word whose subcode is defined at the current level.
   function automatic frame_word_type random_data_word(input int position);
      frame_word_type w;
      w = make_word($urandom, CODE_NONE, 4'(position), 1'b0, 1'b0, 1'b0);
      if ($urandom_range(9) != 0) w.code = 2'($urandom_range(CODE_BYTE, CODE_WORD));
      if (level_reg == LEVEL_STEIM2) begin
         if (w.code == CODE_HALF)
            w.word[31:30] = 2'($urandom_range(SUB2_ONE_30, SUB2_THREE_10));
         else if (w.code == CODE_WORD)
            w.word[31:30] = 2'($urandom_range(SUB3_FIVE_6, SUB3_SEVEN_4));
      end
      return w;
   endfunction

   // Offers one word after a random idle gap and holds it until accepted.
   task automatic send_word(input frame_word_type w);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_word <= w.word;
      req_code <= w.code;
      req_word_index <= w.position;
      req_first_of_record <= w.opens;
      req_last_of_record <= w.closes;
      req_begin_event <= w.begin_event;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      integrate_word(w);
      words_accepted++;
   endtask

   // Stops offering words and waits until every result has come back.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
         input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_STEIM_LEVEL) level_reg = data[1:0];
      else if (index == CSR_CONTEXT_CHECK) ctx_enable = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes both registers with random upper bits, plus one unused index.
   task automatic configure_decoder(input logic [1:0] level, input logic enable);
      logic [CSR_DATA_WIDTH-1:0] data;
      wait_until_idle();
      data = $urandom;
      data[1:0] = level;
      write_csr(CSR_STEIM_LEVEL, data);
      data = $urandom;
      data[0] = enable;
      write_csr(CSR_CONTEXT_CHECK, data);
      write_csr($urandom_range(1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH, $urandom);
   endtask

   // Sends one record: constants in words 0 and 1 unless the shape omits them, then random data words.
   // Constants are chosen so that a clean record passes both checks.
   task automatic send_record(input int data_words, input record_shape_type shape);
      frame_word_type body[$];
      frame_word_type w;
      logic [6:0][31:0] diffs;
      logic [31:0] lead_diff;
      logic [31:0] tail_sum;
      logic [31:0] forward;
      logic [31:0] reverse;
      logic event_flag;
      logic seen;
      int n;
      int start;
      seen = 1'b0;
      lead_diff = '0;
      tail_sum = '0;
      event_flag = ($urandom_range(4) == 0);
      start = (shape == RECORD_NO_CONSTANTS) ? 0 : 2;
      for (int i = 0; i < data_words; i++) begin
         w = random_data_word((start + i) % WORDS_PER_FRAME);
         n = unpack_differences(w.word, w.code, level_reg, diffs);
         for (int s = 0; s < n; s++) begin
            if (seen) begin
               tail_sum = tail_sum + diffs[s];
            end else begin
               seen = 1'b1;
               lead_diff = diffs[s];
            end
         end
         body.push_back(w);
      end
      forward = prev_rev + lead_diff;
      reverse = forward + tail_sum;
      if (shape == RECORD_BAD_CONSTANTS) begin
         if ($urandom_range(1)) forward = forward ^ (32'd1 << $urandom_range(31));
         else reverse = reverse + 32'($urandom_range(1, 255));
      end
      if (shape != RECORD_NO_CONSTANTS) begin
         body.push_front(make_word(reverse, CODE_NONE, FRAME_WORD_REVERSE, 1'b0, 1'b0, 1'b0));
         body.push_front(make_word(forward, CODE_NONE, FRAME_WORD_FORWARD, 1'b0, 1'b0, 1'b0));
      end
      for (int i = 0; i < body.size(); i++) begin
         w = body[i];
         w.opens = (i == 0) && (shape != RECORD_NO_START);
         w.closes = (i == body.size() - 1);
         w.begin_event = event_flag;
         send_word(w);
      end
   endtask

   // Words with every field random, including out-of-range positions.
   task automatic send_noise(input int count);
      frame_word_type w;
      repeat (count) begin
         w.word = $urandom;
         w.code = 2'($urandom_range(3));
         w.position = 4'($urandom_range(15));
         w.opens = ($urandom_range(5) == 0);
         w.closes = ($urandom_range(5) == 0);
         w.begin_event = 1'($urandom_range(1));
         send_word(w);
      end
   endtask

   // Steim 1 record with the extremes of every slot width and a wrapping sum.
   task automatic test_steim1_words();
      configure_decoder(LEVEL_STEIM1, 1'b1);
      send_word(make_word(32'h7FFF_FFF0, CODE_NONE, FRAME_WORD_FORWARD, 1'b1, 1'b0, 1'b0));
      send_word(make_word(32'h8000_0005, CODE_NONE, FRAME_WORD_REVERSE, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'h7F80_00FF, CODE_BYTE, 4'd2, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'h7FFF_8000, CODE_HALF, 4'd3, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'h8000_0000, CODE_WORD, 4'd4, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'h7FFF_FFFF, CODE_WORD, 4'd14, 1'b0, 1'b1, 1'b0));
   endtask

   // Every Steim 2 subcode, both undefined types included.
   task automatic test_steim2_words();
      configure_decoder(LEVEL_STEIM2, 1'b1);
      send_word(make_word(32'h0000_0064, CODE_NONE, FRAME_WORD_FORWARD, 1'b1, 1'b0, 1'b0));
      send_word(make_word(32'hFFFF_FF9C, CODE_NONE, FRAME_WORD_REVERSE, 1'b0, 1'b0, 1'b0));
      send_word(make_word({SUB2_ONE_30, 30'h2000_0000}, CODE_HALF, 4'd2, 1'b0, 1'b0, 1'b0));
      send_word(make_word({SUB2_TWO_15, 15'h3FFF, 15'h4000}, CODE_HALF, 4'd3,
                          1'b0, 1'b0, 1'b0));
      send_word(make_word({SUB2_THREE_10, 10'h1FF, 10'h200, 10'h3FF}, CODE_HALF, 4'd4,
                          1'b0, 1'b0, 1'b0));
      send_word(make_word({SUB3_FIVE_6, 6'h1F, 6'h20, 6'h3F, 6'h00, 6'h01}, CODE_WORD, 4'd5,
                          1'b0, 1'b0, 1'b0));
      send_word(make_word({SUB3_SIX_5, 5'h0F, 5'h10, 5'h1F, 5'h00, 5'h01, 5'h11}, CODE_WORD,
                          4'd6, 1'b0, 1'b0, 1'b0));
      // The two bits below the subcode are unused in the seven-slot layout.
      send_word(make_word({SUB3_SEVEN_4, 2'b11, 4'h7, 4'h8, 4'hF, 4'h0, 4'h1, 4'h9, 4'h6},
                          CODE_WORD, 4'd7, 1'b0, 1'b0, 1'b0));
      send_word(make_word({SUB2_UNDEFINED, 30'h1555_5555}, CODE_HALF, 4'd8, 1'b0, 1'b0, 1'b0));
      send_word(make_word({SUB3_UNDEFINED, 30'h2AAA_AAAA}, CODE_WORD, 4'd9, 1'b0, 1'b1, 1'b0));
   endtask

   // Record framing corners: one-word record, late constants, missing start.
   task automatic test_record_corners();
      configure_decoder(LEVEL_STEIM1, 1'b1);
      // One word opens and closes a record, sits beyond the frame and has no constants.
      send_word(make_word(32'h0102_FEFF, CODE_BYTE, 4'd15, 1'b1, 1'b1, 1'b1));
      // Constants arriving after the first difference do not reload the sum.
      send_word(make_word(32'h0010_FFF0, CODE_HALF, 4'd2, 1'b1, 1'b0, 1'b0));
      send_word(make_word(32'h1111_1111, CODE_NONE, FRAME_WORD_FORWARD, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'h2222_2222, CODE_NONE, FRAME_WORD_REVERSE, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'hFFFF_FFFE, CODE_WORD, 4'd3, 1'b0, 1'b1, 1'b0));
      // No record start, and a word between the two constant words breaks the pair.
      send_word(make_word(32'h3333_3333, CODE_NONE, FRAME_WORD_FORWARD, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'h4444_4444, CODE_NONE, 4'd2, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'h5555_5555, CODE_NONE, FRAME_WORD_REVERSE, 1'b0, 1'b0, 1'b0));
      send_word(make_word(32'h0000_0001, CODE_WORD, 4'd3, 1'b0, 1'b1, 1'b0));
   endtask

   // Mostly well-formed records with random content, some flawed, some noise.
   task automatic test_random_records(input int sender_idle, input int receiver_stall,
         input logic [1:0] level, input logic enable, input int word_budget);
      int stop_at;
      int pick;
      int length;
      configure_decoder(level, enable);
      send_idle_pct = sender_idle;
      stall_pct = receiver_stall;
      stop_at = words_accepted + word_budget;
      while (words_accepted < stop_at) begin
         pick = $urandom_range(99);
         length = ($urandom_range(9) == 0) ? $urandom_range(14, 45) : $urandom_range(1, 13);
         if (pick < 60) send_record(length, RECORD_CLEAN);
         else if (pick < 68) send_record(length, RECORD_NO_CONSTANTS);
         else if (pick < 74) send_record(length, RECORD_NO_START);
         else if (pick < 84) send_record(length, RECORD_BAD_CONSTANTS);
         else send_noise($urandom_range(1, 8));
      end
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_output_backpressure();
      configure_decoder(LEVEL_STEIM2, 1'b1);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      send_record(30, RECORD_CLEAN);
   endtask

   // Receiver stall, either from a hold-off count or at random.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic note_mismatch(input string field, input logic [31:0] want,
         input logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("Mismatch at %0t in %s: expected %h, got %h", $realtime, field, want, got);
   endtask

   // Compares each result transaction with the oldest expected one.
   always @(posedge clock) begin : check_decoded_words
      decoded_result_type got;
      decoded_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.sample = {rsp_sample_g, rsp_sample_f, rsp_sample_e, rsp_sample_d,
                       rsp_sample_c, rsp_sample_b, rsp_sample_a};
         got.count = rsp_sample_count;
         got.bad_type = rsp_bad_type;
         got.reverse_bad = rsp_reverse_mismatch;
         got.context_bad = rsp_context_mismatch;
         got.done = rsp_record_done;
         if (expected_decodes.size() == 0) begin
            note_mismatch("result with no word outstanding", '0, 32'(got.count));
         end else begin
            want = expected_decodes.pop_front();
            for (int s = 0; s < 7; s++)
               if (got.sample[s] !== want.sample[s])
                  note_mismatch($sformatf("sample slot %0d", s), want.sample[s], got.sample[s]);
            if (got.count !== want.count)
               note_mismatch("sample_count", 32'(want.count), 32'(got.count));
            if (got.bad_type !== want.bad_type)
               note_mismatch("bad_type", 32'(want.bad_type), 32'(got.bad_type));
            if (got.reverse_bad !== want.reverse_bad)
               note_mismatch("reverse_mismatch", 32'(want.reverse_bad), 32'(got.reverse_bad));
            if (got.context_bad !== want.context_bad)
               note_mismatch("context_mismatch", 32'(want.context_bad), 32'(got.context_bad));
            if (got.done !== want.done)
               note_mismatch("record_done", 32'(want.done), 32'(got.done));
         end
         results_checked++;
         if (got.done === 1'b1) records_closed++;
      end
   end

   // Ends the run when no transaction of any kind happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Reset, then the directed tests, the random phases and the final check.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_word = '0;
      req_code = CODE_NONE;
      req_word_index = '0;
      req_first_of_record = 1'b0;
      req_last_of_record = 1'b0;
      req_begin_event = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_STEIM_LEVEL;
      csr_wdata = '0;
      level_reg = LEVEL_RESET;
      ctx_enable = 1'b1;
      clear_record_state();
      prev_rev = '0;
      ctx_valid = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_steim1_words();
      test_steim2_words();
      test_record_corners();
      test_random_records(0, 0, LEVEL_STEIM1, 1'b1, 210);
      test_random_records(70, 0, LEVEL_STEIM2, 1'b1, 210);
      test_random_records(0, 70, LEVEL_UNUSED_HIGH, 1'b0, 210);
      test_random_records(13, 13, LEVEL_UNUSED_LOW, 1'b1, 210);
      test_random_records(13, 13, LEVEL_STEIM2, 1'b0, 210);
      test_output_backpressure();

      send_idle_pct = 0;
      stall_pct = 0;
      wait_until_idle();
      repeat (8) @(posedge clock);

      $display("Decoded %0d words into %0d checked results closing %0d records.",
               words_accepted, results_checked, records_closed);
      $display("Covered Steim 1 and 2 at every level value, context check on and off, %s",
               "random idle and stall phases and a long output hold-off.");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
